// ===== rtl/core/shkd_pkg.sv =====
// Types, key codes and the half-step coil table for the key-driven stepper sequencer.
// No dependencies; used by shkd_step and stepper_half_step_key_drive.
`default_nettype none

package shkd_pkg;

    // Run modes as seen on the run_mode output.
    typedef enum logic [1:0] {
        RUN_IDLE = 2'd0,
        RUN_FWD  = 2'd1,
        RUN_REV  = 2'd2
    } t_run;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_MIN_DELAY = 2'd0,
        CFG_MAX_DELAY = 2'd1,
        CFG_DELAY_INC = 2'd2
    } t_cfg_index;

    localparam logic [7:0] KEY_MASK    = 8'h8F;
    localparam logic [7:0] KEY_FORWARD = 8'h8E;
    localparam logic [7:0] KEY_REVERSE = 8'h8D;
    localparam logic [7:0] KEY_FASTER  = 8'h8B;
    localparam logic [7:0] KEY_SLOWER  = 8'h87;
    localparam logic [7:0] KEY_STOP    = 8'h0F;

    localparam logic [7:0] SPEED_BASE = 8'd140;
    localparam logic [7:0] DELAY_RESET = 8'd65;
    localparam logic [2:0] LAST_PHASE = 3'd7;

    localparam logic [7:0] MIN_DELAY_RESET = 8'd40;
    localparam logic [7:0] MAX_DELAY_RESET = 8'd100;
    localparam logic [5:0] DELAY_INC_RESET = 6'd5;

    typedef struct packed {
        logic [7:0] min_delay;
        logic [7:0] max_delay;
        logic [5:0] delay_inc;
    } t_cfg;

    typedef struct packed {
        logic       fwd_req;
        logic       rev_req;
        logic       fast_req;
        logic       slow_req;
        logic [7:0] step_delay;
        t_run       active_run;
        logic [2:0] phase;
        logic [7:0] hold_count;
        logic [3:0] coil;
    } t_state;

    typedef struct packed {
        logic [3:0] coil;
        logic [1:0] run_mode;
        logic [7:0] speed_level;
    } t_result;

    // Half-step coil pattern for one table position.
    function automatic logic [3:0] coil_pattern(input logic [2:0] idx);
        logic [3:0] pat;
        case (idx)
            3'd0:    pat = 4'h9;
            3'd1:    pat = 4'h8;
            3'd2:    pat = 4'hC;
            3'd3:    pat = 4'h4;
            3'd4:    pat = 4'h6;
            3'd5:    pat = 4'h2;
            3'd6:    pat = 4'h3;
            3'd7:    pat = 4'h1;
            default: pat = 4'h0;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/stepper_half_step_key_drive.sv =====
// Half-step stepper sequencer driven by key scans, top level.
// Instantiates shkd_step; depends on shkd_pkg.
//
// Each input item is one tick carrying the key port byte and a scan flag, and each
// item yields exactly one result item: coil pattern, run mode and speed level after
// that tick's update. One item is accepted per clock cycle while o_stall is low; its result
// goes into the result register, or into the skid register if a result waits. The whole
// tick update (key decode, hold countdown, clamped speed change, coil table lookup) is one
// pass of logic into the state and result registers. A two-entry output buffer (result
// register plus skid register) lets the block keep accepting while a result waits; o_stall
// rises only when both entries are full. Configuration writes take effect at the next tick.
`default_nettype none

module stepper_half_step_key_drive (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Configuration write port.
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    // Tick input channel.
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_key_port,
    input  wire logic       i_scan,
    // Result channel.
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [3:0]      o_coil,
    output logic [1:0]      o_run_mode,
    output logic [7:0]      o_speed_level
);
    import shkd_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    in_accept;
    logic    out_take;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_delay <= MIN_DELAY_RESET;
            r_cfg.max_delay <= MAX_DELAY_RESET;
            r_cfg.delay_inc <= DELAY_INC_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIN_DELAY: r_cfg.min_delay <= i_cfg_data;
                CFG_MAX_DELAY: r_cfg.max_delay <= i_cfg_data;
                CFG_DELAY_INC: r_cfg.delay_inc <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    assign in_accept = i_valid && !r_skid_valid;
    assign out_take  = r_out_valid && !i_stall;

    // Tick update logic.
    shkd_step u_step (
        .i_state    (r_state),
        .i_cfg      (r_cfg),
        .i_key_port (i_key_port),
        .i_scan     (i_scan),
        .o_state    (n_state),
        .o_result   (n_result)
    );

    // Sequencer state advances once per accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.fwd_req    <= 1'b0;
            r_state.rev_req    <= 1'b0;
            r_state.fast_req   <= 1'b0;
            r_state.slow_req   <= 1'b0;
            r_state.step_delay <= DELAY_RESET;
            r_state.active_run <= RUN_IDLE;
            r_state.phase      <= 3'd0;
            r_state.hold_count <= 8'd0;
            r_state.coil       <= 4'h0;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // Output buffer: result register fed from the skid register or straight from the logic.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_take) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_accept;
                end
            end else if (in_accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_accept) begin
                r_out <= n_result;
            end
        end else if (in_accept) begin
            r_skid <= n_result;
        end
    end

    assign o_stall       = r_skid_valid;
    assign o_valid       = r_out_valid;
    assign o_coil        = r_out.coil;
    assign o_run_mode    = r_out.run_mode;
    assign o_speed_level = r_out.speed_level;

`ifndef SYNTH
    // The skid entry is only ever filled behind a waiting result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid without a result in the output register");

    // An idle sequencer holds no countdown.
    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.active_run == RUN_IDLE) |-> (r_state.hold_count == 8'd0))
        else $error("hold count nonzero while idle");

    // A running pattern always has at least one tick left.
    a_run_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state.active_run == RUN_FWD) || (r_state.active_run == RUN_REV))
        |-> (r_state.hold_count != 8'd0))
        else $error("running pattern with zero hold count");

    // A result held under stall does not change, even while new items are accepted.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> $stable(r_out))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/shkd_step.sv =====
// Next-state and result logic for one tick item of the stepper sequencer.
// Purely combinational; depends on shkd_pkg.
`default_nettype none

module shkd_step (
    input  wire shkd_pkg::t_state  i_state,
    input  wire shkd_pkg::t_cfg    i_cfg,
    input  wire logic [7:0]        i_key_port,
    input  wire logic              i_scan,
    output shkd_pkg::t_state       o_state,
    output shkd_pkg::t_result      o_result
);
    import shkd_pkg::*;

    logic [7:0] keys;
    t_state     s_scan;
    logic [8:0] dec_diff;
    logic [8:0] inc_sum;
    logic [7:0] new_delay;
    logic [7:0] load_hold;
    logic [2:0] next_phase;
    logic       go_idle;
    t_state     s_next;

    assign keys = i_key_port & KEY_MASK;

    // Key decode on a scan tick.
    always_comb begin
        s_scan = i_state;
        if (i_scan) begin
            case (keys)
                KEY_FORWARD: s_scan.fwd_req  = 1'b1;
                KEY_REVERSE: s_scan.rev_req  = 1'b1;
                KEY_FASTER:  s_scan.fast_req = 1'b1;
                KEY_SLOWER:  s_scan.slow_req = 1'b1;
                KEY_STOP: begin
                    s_scan.fwd_req = 1'b0;
                    s_scan.rev_req = 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Clamped delay after a pending speed change; faster has priority.
    assign dec_diff = {1'b0, i_state.step_delay} - {3'b000, i_cfg.delay_inc};
    assign inc_sum  = {1'b0, i_state.step_delay} + {3'b000, i_cfg.delay_inc};

    always_comb begin
        if (s_scan.fast_req) begin
            if (dec_diff[8] || (dec_diff[7:0] < i_cfg.min_delay)) begin
                new_delay = i_cfg.min_delay;
            end else begin
                new_delay = dec_diff[7:0];
            end
        end else if (s_scan.slow_req) begin
            if (inc_sum > {1'b0, i_cfg.max_delay}) begin
                new_delay = i_cfg.max_delay;
            end else begin
                new_delay = inc_sum[7:0];
            end
        end else begin
            new_delay = i_state.step_delay;
        end
    end

    // A run either counts down, steps to the next pattern, or ends and drops into idle work.
    assign next_phase = i_state.phase + 3'd1;
    assign go_idle    = !((i_state.active_run == RUN_FWD) || (i_state.active_run == RUN_REV))
                        || ((i_state.hold_count <= 8'd1) && (i_state.phase == LAST_PHASE));

    always_comb begin
        s_next    = s_scan;
        load_hold = 8'd1;
        if (!go_idle) begin
            if (i_state.hold_count > 8'd1) begin
                s_next.hold_count = i_state.hold_count - 8'd1;
            end else begin
                s_next.phase = next_phase;
                s_next.coil  = coil_pattern((i_state.active_run == RUN_REV) ?
                                            (LAST_PHASE - next_phase) : next_phase);
                s_next.hold_count = (i_state.step_delay != 8'd0) ? i_state.step_delay : 8'd1;
            end
        end else begin
            s_next.active_run = RUN_IDLE;
            s_next.hold_count = 8'd0;
            s_next.step_delay = new_delay;
            if (s_scan.fast_req) begin
                s_next.fast_req = 1'b0;
            end else if (s_scan.slow_req) begin
                s_next.slow_req = 1'b0;
            end
            if (new_delay != 8'd0) begin
                load_hold = new_delay;
            end
            // Start of a new run loads the first pattern of its direction.
            if (s_scan.fwd_req) begin
                s_next.active_run = RUN_FWD;
                s_next.phase      = 3'd0;
                s_next.coil       = coil_pattern(3'd0);
                s_next.hold_count = load_hold;
            end else if (s_scan.rev_req) begin
                s_next.active_run = RUN_REV;
                s_next.phase      = 3'd0;
                s_next.coil       = coil_pattern(LAST_PHASE);
                s_next.hold_count = load_hold;
            end
        end
    end

    assign o_state              = s_next;
    assign o_result.coil        = s_next.coil;
    assign o_result.run_mode    = s_next.active_run;
    assign o_result.speed_level = SPEED_BASE - s_next.step_delay;

endmodule

`default_nettype wire
